>>> src/hmhe_pkg.sv
// hmhe_pkg: shared types and codes of the huffman merge heap engine
// no dependencies
`default_nettype none
package hmhe_pkg;
   localparam int ID_W    = 9;
   localparam int FREQ_W  = 32;
   localparam int COUNT_W = 9;
   localparam int MERGE_W = 8;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_BUILD   = 2'd1,
      CMD_MERGE   = 2'd2,
      CMD_EXTRACT = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_FEW  = 2'd2,
      ST_SAT  = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [FREQ_W-1:0] freq;
   } entry_type;
endpackage
`default_nettype wire

>>> src/huffman_merge_heap_engine.sv
// huffman_merge_heap_engine: memory-held binary min-heap for huffman tree building
// depends on hmhe_pkg
//
// One request word is taken at a time and gives one response word. The heap lives
// in a single-port-read, single-port-write memory with a registered read port;
// each sift-down level reads the left child, reads the right child and writes
// back, and each sift-up level reads the parent and then compares and writes.
// A finished response waits in an output register while the next request is taken.
`default_nettype none
module huffman_merge_heap_engine
   import hmhe_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_command,
   input  wire logic [7:0]           req_symbol,
   input  wire logic [FREQ_W-1:0]    req_frequency,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [ID_W-1:0]           rsp_first_id,
   output logic [FREQ_W-1:0]         rsp_first_frequency,
   output logic [ID_W-1:0]           rsp_second_id,
   output logic [FREQ_W-1:0]         rsp_second_frequency,
   output logic [ID_W-1:0]           rsp_new_id,
   output logic [COUNT_W-1:0]        rsp_entry_count
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_BRD, S_BCUR, S_SDL, S_SDLW, S_SDRW, S_T0, S_TL, S_TCUR,
      S_ISTART, S_IRD, S_ICMP, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_BUILD, PH_TAKE1, PH_TAKE2, PH_EXTRACT
   } phase_type;

   state_type         state_ff;
   phase_type         phase_ff;
   logic [CW-1:0]     count_ff;
   logic [MERGE_W-1:0] mc_ff;
   logic [AW-1:0]     pos_ff;
   logic [AW-1:0]     bidx_ff;
   entry_type         cur_ff;
   entry_type         best_ff;
   logic [AW-1:0]     best_idx_ff;
   logic              best_self_ff;
   logic              r_ok_ff;
   status_type        st_ff;
   entry_type         first_ff;
   entry_type         second_ff;
   logic [ID_W-1:0]   nid_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   entry_type         rsp_first_ff;
   entry_type         rsp_second_ff;
   logic [ID_W-1:0]   rsp_new_id_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   entry_type         mem [CAPACITY];
   entry_type         rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_data;

   logic              accept;
   logic [AW+1:0]     l_idx;
   logic [AW+1:0]     r_idx;
   logic [AW+1:0]     cnt_x;
   logic              l_ok;
   logic              take_l;
   logic              take_r;
   entry_type         fin;
   logic              fin_self;
   logic [AW-1:0]     fin_idx;
   logic              sift_end;
   logic [AW-1:0]     parent;
   logic [CW-1:0]     cnt_m1;
   logic [FREQ_W:0]   sum;
   logic              out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign l_idx  = {1'b0, pos_ff, 1'b1};
   assign r_idx  = l_idx + (AW+2)'(1);
   assign cnt_x  = (AW+2)'(count_ff);
   assign l_ok   = l_idx < cnt_x;
   assign cnt_m1 = count_ff - CW'(1);
   assign parent = (pos_ff - AW'(1)) >> 1;
   assign sum    = {1'b0, first_ff.freq} + {1'b0, second_ff.freq};

   // strict compares, left child before right
   assign take_l   = rd_data_ff.freq < cur_ff.freq;
   assign take_r   = r_ok_ff && (rd_data_ff.freq < best_ff.freq);
   assign fin      = take_r ? rd_data_ff : best_ff;
   assign fin_self = !take_r && best_self_ff;
   assign fin_idx  = take_r ? r_idx[AW-1:0] : best_idx_ff;
   assign sift_end = ((state_ff == S_SDL) && !l_ok) || ((state_ff == S_SDRW) && fin_self);

   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = cur_ff;
      case (state_ff)
         S_IDLE: begin
            wr_addr = count_ff[AW-1:0];
            wr_data = '{id: ID_W'(req_symbol), freq: req_frequency};
            wr_en   = accept && (req_command == CMD_LOAD) && (count_ff < CW'(CAPACITY));
         end
         S_BRD:  rd_addr = bidx_ff;
         S_SDL: begin
            rd_addr = l_idx[AW-1:0];
            wr_en   = !l_ok;
         end
         S_SDLW: rd_addr = r_idx[AW-1:0];
         S_SDRW: begin
            wr_en = 1'b1;
            if (!fin_self) begin
               wr_data = fin;
            end
         end
         S_T0:   rd_addr = '0;
         S_TL:   rd_addr = cnt_m1[AW-1:0];
         S_IRD: begin
            rd_addr = parent;
            wr_en   = (pos_ff == '0);
         end
         S_ICMP: begin
            wr_en = 1'b1;
            if (cur_ff.freq < rd_data_ff.freq) begin
               wr_data = rd_data_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  first_ff  <= '0;
                  second_ff <= '0;
                  nid_ff    <= '0;
                  case (command_type'(req_command))
                     CMD_LOAD: begin
                        state_ff <= S_DONE;
                        if (count_ff >= CW'(CAPACITY)) begin
                           st_ff <= ST_FULL;
                        end else begin
                           st_ff    <= ST_OK;
                           count_ff <= count_ff + CW'(1);
                        end
                     end
                     CMD_BUILD: begin
                        st_ff    <= ST_OK;
                        mc_ff    <= '0;
                        bidx_ff  <= AW'(count_ff >> 1);
                        phase_ff <= PH_BUILD;
                        state_ff <= S_BRD;
                     end
                     CMD_MERGE: begin
                        if (count_ff < CW'(2)) begin
                           st_ff    <= ST_FEW;
                           state_ff <= S_DONE;
                        end else begin
                           st_ff    <= ST_OK;
                           phase_ff <= PH_TAKE1;
                           state_ff <= S_T0;
                        end
                     end
                     default: begin
                        if (count_ff == '0) begin
                           st_ff    <= ST_FEW;
                           state_ff <= S_DONE;
                        end else begin
                           st_ff    <= ST_OK;
                           phase_ff <= PH_EXTRACT;
                           state_ff <= S_T0;
                        end
                     end
                  endcase
               end
            end
            S_BRD:  state_ff <= S_BCUR;
            S_BCUR: begin
               cur_ff   <= rd_data_ff;
               pos_ff   <= bidx_ff;
               state_ff <= S_SDL;
            end
            S_SDL: begin
               if (l_ok) begin
                  state_ff <= S_SDLW;
               end
            end
            S_SDLW: begin
               best_ff      <= take_l ? rd_data_ff : cur_ff;
               best_self_ff <= !take_l;
               best_idx_ff  <= l_idx[AW-1:0];
               r_ok_ff      <= r_idx < cnt_x;
               state_ff     <= S_SDRW;
            end
            S_SDRW: begin
               if (!fin_self) begin
                  pos_ff   <= fin_idx;
                  state_ff <= S_SDL;
               end
            end
            S_T0:   state_ff <= S_TL;
            S_TL: begin
               if (phase_ff == PH_TAKE2) begin
                  second_ff <= rd_data_ff;
               end else begin
                  first_ff <= rd_data_ff;
               end
               count_ff <= cnt_m1;
               state_ff <= S_TCUR;
            end
            S_TCUR: begin
               cur_ff   <= rd_data_ff;
               pos_ff   <= '0;
               state_ff <= S_SDL;
            end
            S_ISTART: begin
               cur_ff.id   <= {1'b1, mc_ff};
               cur_ff.freq <= sum[FREQ_W] ? '1 : sum[FREQ_W-1:0];
               if (sum[FREQ_W]) begin
                  st_ff <= ST_SAT;
               end
               nid_ff   <= {1'b1, mc_ff};
               mc_ff    <= mc_ff + MERGE_W'(1);
               pos_ff   <= count_ff[AW-1:0];
               count_ff <= count_ff + CW'(1);
               state_ff <= S_IRD;
            end
            S_IRD: begin
               state_ff <= (pos_ff == '0) ? S_DONE : S_ICMP;
            end
            S_ICMP: begin
               if (cur_ff.freq < rd_data_ff.freq) begin
                  pos_ff   <= parent;
                  state_ff <= S_IRD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= st_ff;
                  rsp_first_ff  <= first_ff;
                  rsp_second_ff <= second_ff;
                  rsp_new_id_ff <= nid_ff;
                  rsp_count_ff  <= COUNT_W'(count_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // continuation once a sift-down has settled
         if (sift_end) begin
            case (phase_ff)
               PH_BUILD: begin
                  if (bidx_ff == '0) begin
                     state_ff <= S_DONE;
                  end else begin
                     bidx_ff  <= bidx_ff - AW'(1);
                     state_ff <= S_BRD;
                  end
               end
               PH_TAKE1: begin
                  phase_ff <= PH_TAKE2;
                  state_ff <= S_T0;
               end
               PH_TAKE2: state_ff <= S_ISTART;
               default:  state_ff <= S_DONE;
            endcase
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_first_id         = rsp_first_ff.id;
   assign rsp_first_frequency  = rsp_first_ff.freq;
   assign rsp_second_id        = rsp_second_ff.id;
   assign rsp_second_frequency = rsp_second_ff.freq;
   assign rsp_new_id           = rsp_new_id_ff;
   assign rsp_entry_count      = rsp_count_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("heap count beyond capacity");

   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FEW) |-> (rsp_first_id == '0) && (rsp_new_id == '0))
      else $error("rejected word carries node data");

   a_new_id_internal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_new_id != '0) |-> rsp_new_id[ID_W-1] && (rsp_second_id != rsp_new_id))
      else $error("merge id not an internal node");
endmodule
`default_nettype wire
